// File: src/cxyz_pkg.sv
package cxyz_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VW = 24;
    // dividend width: 24 bits shifted by FRAC_BITS, or a 17x24 product
    localparam int NW = 48;
    // divisor width: sum of three 24-bit values
    localparam int DW = 26;
    localparam int QW = NW;
    localparam int STAGES = NW;

    localparam logic [VW-1:0] MAXV = {VW{1'b1}};
    localparam logic [VW-1:0] ONE_FX = VW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] HUNDRED_FX = VW'(100) << FRAC_BITS;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DARK = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    typedef struct packed {
        logic          mode;
        logic [VW-1:0] in_a;
        logic [VW-1:0] in_b;
        logic [VW-1:0] in_c;
    } in_word_t;

    typedef struct packed {
        logic [VW-1:0] out_a;
        logic [VW-1:0] out_b;
        logic [VW-1:0] out_c;
        logic [1:0]    status;
    } out_word_t;

    // side information carried alongside the two division lanes
    typedef struct packed {
        logic          vld;
        logic          mode;
        logic          force_zero;  // dark pixel or small sum
        logic          zero_div;    // y == 0 (mode 0) or sum == 0 (mode 1)
        logic          neg_z;       // x + y above one
        logic [1:0]    st;
        logic [VW-1:0] pass_a;      // mode 1 out_a
        logic [VW-1:0] pass_b;      // mode 0 out_b
    } side_t;

    // one lane of restoring division state
    typedef struct packed {
        logic [NW-1:0] num;
        logic [DW:0]   rem;
        logic [QW-1:0] quo;
    } lane_t;

endpackage

// File: src/cxyz_div_cell.sv
module cxyz_div_cell
    import cxyz_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  side_t         side_in,
    input  lane_t         lane0_in,
    input  lane_t         lane1_in,
    input  logic [DW-1:0] den_in,
    output side_t         side_out,
    output lane_t         lane0_out,
    output lane_t         lane1_out,
    output logic [DW-1:0] den_out
);

    side_t         side_reg;
    lane_t         lane0_reg;
    lane_t         lane1_reg;
    logic [DW-1:0] den_reg;
    lane_t         lane0_next;
    lane_t         lane1_next;

    function automatic lane_t step(input lane_t l, input logic [DW-1:0] d);
        logic [DW:0]   r;
        logic [DW+1:0] t;
        lane_t         o;
        begin
            r = {l.rem[DW-1:0], l.num[NW-1]};
            t = {1'b0, r} - {2'b00, d};
            o.num = {l.num[NW-2:0], 1'b0};
            if (!t[DW+1])
            begin
                o.rem = t[DW:0];
                o.quo = {l.quo[QW-2:0], 1'b1};
            end
            else
            begin
                o.rem = r;
                o.quo = {l.quo[QW-2:0], 1'b0};
            end
            step = o;
        end
    endfunction

    always_comb
    begin
        lane0_next = step(lane0_in, den_in);
        lane1_next = step(lane1_in, den_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        lane0_reg           <= lane0_next;
        lane1_reg           <= lane1_next;
        den_reg             <= den_in;
    end

    assign side_out  = side_reg;
    assign lane0_out = lane0_reg;
    assign lane1_out = lane1_reg;
    assign den_out   = den_reg;

endmodule

// File: src/cie_xyy_xyz_converter.sv
// channel   direction  handshake             payload
// ------    ---------  --------------------  --------------------------
// command   in         start / busy          cmd (mode, in_a, in_b, in_c)
// result    out        done strobe           result (out_a..c, status)
// config    in         cfg_valid / cfg_ready cfg_data (zero_threshold)
//
// one word accepted per clock; busy is never raised
// pipeline: 1 front-end stage, 1 multiply stage, 48 divider cells, 1 output
// stage, each registered, in that order from command word to result
// reset clears the valid chain and sets zero_threshold to 1
// the receiver cannot stall; results are shown for exactly one cycle
module cie_xyy_xyz_converter
    import cxyz_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_word_t   cmd,
    output logic       done,
    output out_word_t  result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0] thr_reg;

    // stage 1: clamp, classify, form dividend factors
    side_t         s1_reg;
    logic [VW-1:0] s1_fa_reg;   // mode0 cx / mode1 a
    logic [VW-1:0] s1_fc_reg;   // mode0 1-x-y / mode1 b
    logic [VW-1:0] s1_lum_reg;
    logic [DW-1:0] s1_den_reg;

    // stage 2: dividends registered (products or shifted values)
    side_t         s2_reg;
    logic [NW-1:0] s2_p0_reg;
    logic [NW-1:0] s2_p1_reg;
    logic [DW-1:0] s2_den_reg;

    side_t         s1_next;
    logic [VW-1:0] fa_next;
    logic [VW-1:0] fc_next;
    logic [VW-1:0] lum;
    logic [VW-1:0] cx;
    logic [VW-1:0] cy;
    logic [DW-1:0] sum;
    logic [VW:0]   cxy;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    always_comb
    begin
        lum = cmd.in_a;
        cx  = cmd.in_b;
        cy  = cmd.in_c;
        s1_next = '0;
        s1_next.vld  = start;
        s1_next.mode = cmd.mode;
        s1_next.st   = ST_OK;
        sum = DW'(cmd.in_a) + DW'(cmd.in_b) + DW'(cmd.in_c);
        fa_next = '0;
        fc_next = '0;
        cxy = '0;
        if (!cmd.mode)
        begin
            if (lum > HUNDRED_FX)
            begin
                lum = HUNDRED_FX;
                s1_next.st = ST_SAT;
            end
            if (cx > ONE_FX)
            begin
                cx = ONE_FX;
                s1_next.st = ST_SAT;
            end
            if (cy > ONE_FX)
            begin
                cy = ONE_FX;
                s1_next.st = ST_SAT;
            end
            cxy = {1'b0, cx} + {1'b0, cy};
            s1_next.force_zero = lum < VW'(thr_reg);
            s1_next.zero_div   = cy == '0;
            s1_next.neg_z      = cxy > {1'b0, ONE_FX};
            s1_next.pass_b     = lum;
            fa_next = cx;
            fc_next = s1_next.neg_z ? '0 : VW'({1'b0, ONE_FX} - cxy);
        end
        else
        begin
            s1_next.force_zero = sum < DW'(thr_reg);
            s1_next.zero_div   = sum == '0;
            s1_next.pass_a     = cmd.in_b;
            fa_next = cmd.in_a;
            fc_next = cmd.in_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_fa_reg  <= fa_next;
        s1_fc_reg  <= fc_next;
        s1_lum_reg <= cmd.mode ? '0 : lum;
        s1_den_reg <= cmd.mode ? sum : DW'(cy);

        s2_den_reg        <= s1_den_reg;
        // mode 0 multiplies by luminance (17x24 bits), mode 1 shifts
        if (s1_reg.mode)
        begin
            s2_p0_reg <= NW'(s1_fa_reg) << FRAC_BITS;
            s2_p1_reg <= NW'(s1_fc_reg) << FRAC_BITS;
        end
        else
        begin
            s2_p0_reg <= NW'(s1_fa_reg) * NW'(s1_lum_reg);
            s2_p1_reg <= NW'(s1_fc_reg) * NW'(s1_lum_reg);
        end
    end

    // chain of divider cells, one quotient bit per cell
    side_t         side_c  [STAGES+1];
    lane_t         lane0_c [STAGES+1];
    lane_t         lane1_c [STAGES+1];
    logic [DW-1:0] den_c   [STAGES+1];

    assign side_c[0]       = s2_reg;
    assign lane0_c[0].num  = s2_p0_reg;
    assign lane0_c[0].rem  = '0;
    assign lane0_c[0].quo  = '0;
    assign lane1_c[0].num  = s2_p1_reg;
    assign lane1_c[0].rem  = '0;
    assign lane1_c[0].quo  = '0;
    // a zero divisor is patched later; divide by one to keep the cells tidy
    assign den_c[0]        = (s2_den_reg == '0) ? DW'(1) : s2_den_reg;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        cxyz_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .side_in   (side_c[i]),
            .lane0_in  (lane0_c[i]),
            .lane1_in  (lane1_c[i]),
            .den_in    (den_c[i]),
            .side_out  (side_c[i+1]),
            .lane0_out (lane0_c[i+1]),
            .lane1_out (lane1_c[i+1]),
            .den_out   (den_c[i+1])
        );
    end

    // output stage: saturation and special cases
    side_t         sd;
    out_word_t     res_next;
    logic [QW-1:0] q0;
    logic [QW-1:0] q1;
    logic          done_reg;
    out_word_t     result_reg;

    always_comb
    begin
        sd = side_c[STAGES];
        q0 = lane0_c[STAGES].quo;
        q1 = lane1_c[STAGES].quo;
        res_next = '0;
        res_next.status = sd.st;
        if (sd.force_zero)
        begin
            res_next.status = ST_DARK;
        end
        else if (!sd.mode)
        begin
            res_next.out_b = sd.pass_b;
            if (sd.zero_div)
            begin
                res_next.out_a  = MAXV;
                res_next.out_c  = MAXV;
                res_next.status = ST_SAT;
            end
            else
            begin
                if (q0 > QW'(MAXV))
                begin
                    res_next.out_a  = MAXV;
                    res_next.status = ST_SAT;
                end
                else
                begin
                    res_next.out_a = q0[VW-1:0];
                end
                if (sd.neg_z)
                begin
                    res_next.status = ST_SAT;
                end
                else if (q1 > QW'(MAXV))
                begin
                    res_next.out_c  = MAXV;
                    res_next.status = ST_SAT;
                end
                else
                begin
                    res_next.out_c = q1[VW-1:0];
                end
            end
        end
        else if (sd.zero_div)
        begin
            res_next.status = ST_SAT;
        end
        else
        begin
            res_next.out_a = sd.pass_a;
            // x, y at most one, so never saturate
            res_next.out_b = q0[VW-1:0];
            res_next.out_c = q1[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sd.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    // status three never produced
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status != 2'd3)
        else $error("bad status code");

    // forced-zero results carry zero words
    a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_DARK) |->
            (result.out_a == '0 && result.out_b == '0 && result.out_c == '0))
        else $error("dark result not zero");

    // pipeline depth: each done strobe matches a start that passed the whole pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, STAGES + 3))
        else $error("result without command");
`endif

endmodule
